// ===== hdl/csvp_pkg.sv =====
`timescale 1ns / 1ps
package csvp_pkg;

    // Line counters are as wide as the line number fields and saturate at all ones.
    localparam int LINE_BITS = 24;
    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

    localparam int DEF_MAX_FIELDS = 1024;
    localparam int FPOS_W = 10;
    localparam int TOTAL_W = 11;

    // One input byte causes at most four events.
    localparam int MAX_EVTS = 4;
    localparam int EVT_IDX_W = 2;
    localparam int EVT_CNT_W = 3;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] SEP_RESET = 8'd44;
    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;
    localparam logic [1:0] BOM_DONE = 2'd3;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_EOF,
        KIND_EOR,
        KIND_ERR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_STRAY,
        ERR_UNTERM,
        ERR_COUNT
    } t_err;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SEP,
        CFG_STRICT,
        CFG_HDR
    } t_cfg_idx;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_evt;

    // All events caused by one input byte share everything but kind and data.
    typedef struct packed {
        logic [EVT_CNT_W-1:0]  cnt;
        t_evt [MAX_EVTS-1:0]   evt;
        logic                  quoted;
        logic [FPOS_W-1:0]     pos;
        logic [TOTAL_W-1:0]    total;
        logic                  hdr;
        t_err                  err;
        logic [LINE_BITS-1:0]  line;
        logic [LINE_BITS-1:0]  row_line;
    } t_bundle;

    localparam int OUT_PAYLOAD_W = 8 + 1 + FPOS_W + TOTAL_W + 1 + 2 + 2 * LINE_BITS;
    localparam int M_TDATA_W = ((OUT_PAYLOAD_W + 7) / 8) * 8;

    function automatic logic [7:0] f_bom_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0: r = BOM_B0;
            2'd1: r = BOM_B1;
            default: r = BOM_B2;
        endcase
        return r;
    endfunction

    function automatic t_bundle f_emit(input t_bundle b, input t_kind k, input logic [7:0] d);
        t_bundle r;
        r = b;
        if (b.cnt < EVT_CNT_W'(MAX_EVTS)) begin
            r.evt[b.cnt[EVT_IDX_W-1:0]].kind = k;
            r.evt[b.cnt[EVT_IDX_W-1:0]].data = d;
            r.cnt = b.cnt + 1'b1;
        end
        return r;
    endfunction

    // Emits the byte-order mark bytes matched so far; nothing is held once
    // matching has finished.
    function automatic t_bundle f_flush(input t_bundle b, input logic [1:0] prog);
        t_bundle r;
        r = b;
        for (int i = 0; i < 2; i++) begin
            if (prog != BOM_DONE && 2'(i) < prog) begin
                r = f_emit(r, KIND_BYTE, f_bom_byte(2'(i)));
            end
        end
        return r;
    endfunction

    function automatic logic [LINE_BITS-1:0] f_line_inc(input logic [LINE_BITS-1:0] x);
        return (x == LINE_TOP) ? x : x + 1'b1;
    endfunction

endpackage

// ===== hdl/csvp_front.sv =====
`timescale 1ns / 1ps
module csvp_front #(
    parameter int MAX_FIELDS = csvp_pkg::DEF_MAX_FIELDS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [csvp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [csvp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_accept,
    input  logic [7:0]                       i_byte,
    input  logic                             i_eoi,
    output csvp_pkg::t_bundle                o_bundle
);
    import csvp_pkg::*;

    localparam int CW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam logic [CW-1:0] CNT_TOP = CW'(MAX_FIELDS - 1);

    logic [7:0]           r_sep;
    logic                 r_strict, r_hdr;
    logic                 r_inq, n_inq;
    logic                 r_qp, n_qp;
    logic                 r_swallow, n_swallow;
    logic                 r_fq, n_fq;
    logic                 r_row_open, n_row_open;
    logic                 r_nonempty, n_nonempty;
    logic [LINE_BITS-1:0] r_cur_line, n_cur_line;
    logic [LINE_BITS-1:0] r_row_line, n_row_line;
    logic [LINE_BITS-1:0] r_quote_line, n_quote_line;
    logic [CW-1:0]        r_fcnt, n_fcnt;
    logic [CW:0]          r_expected, n_expected;
    logic                 r_first_seen, n_first_seen;
    logic [1:0]           r_bom, n_bom;
    logic                 r_in_first, n_in_first;
    logic                 r_stopped, n_stopped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
            r_strict <= 1'b0;
            r_hdr <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SEP: r_sep <= i_cfg_wdata[7:0];
                CFG_STRICT: r_strict <= i_cfg_wdata[0];
                CFG_HDR: r_hdr <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        t_bundle              b;
        logic                 handled, do_put, do_push, do_finish, do_bump, do_open;
        logic [7:0]           put_b;
        logic [CW:0]          total;
        logic [LINE_BITS-1:0] ev_line;
        t_err                 ev_err;

        n_inq = r_inq;
        n_qp = r_qp;
        n_swallow = r_swallow;
        n_fq = r_fq;
        n_row_open = r_row_open;
        n_nonempty = r_nonempty;
        n_cur_line = r_cur_line;
        n_row_line = r_row_line;
        n_quote_line = r_quote_line;
        n_fcnt = r_fcnt;
        n_expected = r_expected;
        n_first_seen = r_first_seen;
        n_bom = r_bom;
        n_in_first = r_in_first;
        n_stopped = r_stopped;

        b = '0;
        handled = 1'b0;
        do_put = 1'b0;
        do_push = 1'b0;
        do_finish = 1'b0;
        do_bump = 1'b0;
        do_open = 1'b0;
        put_b = i_byte;
        total = {1'b0, r_fcnt} + 1'b1;
        ev_line = r_cur_line;
        ev_err = ERR_NONE;

        if (!r_stopped) begin
            if (i_eoi) begin
                n_swallow = 1'b0;
                if (r_qp) begin
                    n_qp = 1'b0;
                    n_inq = 1'b0;
                end
                if (n_inq) begin
                    // The line reported is where the open quote began.
                    ev_line = r_quote_line;
                    ev_err = ERR_UNTERM;
                    b = f_emit(b, KIND_ERR, 8'h00);
                    n_stopped = 1'b1;
                end else begin
                    do_finish = 1'b1;
                end
            end else begin
                if (r_swallow) begin
                    n_swallow = 1'b0;
                    if (i_byte == CH_LF) begin
                        handled = 1'b1;
                    end
                end
                if (!handled && r_qp) begin
                    // A held quote is either an escaped quote or the closing one.
                    n_qp = 1'b0;
                    if (i_byte == CH_QUOTE) begin
                        do_put = 1'b1;
                        put_b = CH_QUOTE;
                        handled = 1'b1;
                    end else begin
                        n_inq = 1'b0;
                    end
                end else if (!handled && r_inq) begin
                    handled = 1'b1;
                    if (i_byte == CH_QUOTE) begin
                        n_qp = 1'b1;
                    end else if (i_byte == CH_CR) begin
                        do_put = 1'b1;
                        put_b = CH_LF;
                        do_bump = 1'b1;
                        n_swallow = 1'b1;
                    end else if (i_byte == CH_LF) begin
                        do_put = 1'b1;
                        put_b = CH_LF;
                        do_bump = 1'b1;
                    end else begin
                        do_put = 1'b1;
                    end
                end
                if (!handled) begin
                    if (i_byte == CH_QUOTE) begin
                        if (!r_nonempty && !r_fq) begin
                            do_open = 1'b1;
                            n_inq = 1'b1;
                            n_fq = 1'b1;
                            n_quote_line = r_cur_line;
                        end else begin
                            ev_err = ERR_STRAY;
                            b = f_emit(b, KIND_ERR, 8'h00);
                            n_stopped = 1'b1;
                        end
                    end else if (i_byte == r_sep) begin
                        do_push = 1'b1;
                    end else if (i_byte == CH_CR || i_byte == CH_LF) begin
                        if (i_byte == CH_CR) begin
                            n_swallow = 1'b1;
                        end
                        do_finish = 1'b1;
                        do_bump = 1'b1;
                    end else begin
                        do_open = 1'b1;
                        do_put = 1'b1;
                    end
                end
            end

            if (do_open || do_push) begin
                if (!r_row_open) begin
                    n_row_line = r_cur_line;
                end
                n_row_open = 1'b1;
            end

            if (do_put) begin
                n_nonempty = 1'b1;
                if (r_in_first && r_bom != BOM_DONE) begin
                    if (put_b == f_bom_byte(r_bom)) begin
                        n_bom = r_bom + 1'b1;
                    end else begin
                        b = f_flush(b, r_bom);
                        n_bom = BOM_DONE;
                        b = f_emit(b, KIND_BYTE, put_b);
                    end
                end else begin
                    b = f_emit(b, KIND_BYTE, put_b);
                end
            end

            if (do_push) begin
                if (r_in_first) begin
                    b = f_flush(b, r_bom);
                    n_bom = BOM_DONE;
                    n_in_first = 1'b0;
                end
                b = f_emit(b, KIND_EOF, 8'h00);
                if (r_fcnt != CNT_TOP) begin
                    n_fcnt = r_fcnt + 1'b1;
                end
                n_nonempty = 1'b0;
                n_fq = 1'b0;
            end

            // A blank line has no open record and produces nothing.
            if (do_finish && (r_row_open || r_nonempty || r_fcnt != '0)) begin
                if (r_in_first) begin
                    b = f_flush(b, r_bom);
                    n_bom = BOM_DONE;
                    n_in_first = 1'b0;
                end
                b = f_emit(b, KIND_EOF, 8'h00);
                b = f_emit(b, KIND_EOR, 8'h00);
                if (!r_first_seen) begin
                    n_expected = total;
                    n_first_seen = 1'b1;
                end else if (r_strict && total != r_expected) begin
                    ev_err = ERR_COUNT;
                    b = f_emit(b, KIND_ERR, 8'h00);
                    n_stopped = 1'b1;
                end
                n_fcnt = '0;
                n_nonempty = 1'b0;
                n_fq = 1'b0;
                n_row_open = 1'b0;
            end

            if (do_bump) begin
                n_cur_line = f_line_inc(r_cur_line);
            end
        end

        b.quoted = r_fq;
        b.pos = FPOS_W'(r_fcnt);
        b.total = TOTAL_W'(total);
        b.hdr = r_hdr && !r_first_seen;
        b.err = ev_err;
        b.line = ev_line;
        b.row_line = n_row_line;
        o_bundle = b;

        // A clean end of input starts a fresh stream.
        if (!r_stopped && i_eoi && !n_stopped) begin
            n_inq = 1'b0;
            n_qp = 1'b0;
            n_swallow = 1'b0;
            n_fq = 1'b0;
            n_row_open = 1'b0;
            n_nonempty = 1'b0;
            n_cur_line = LINE_FIRST;
            n_row_line = LINE_FIRST;
            n_quote_line = '0;
            n_fcnt = '0;
            n_expected = '0;
            n_first_seen = 1'b0;
            n_bom = 2'd0;
            n_in_first = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inq <= 1'b0;
            r_qp <= 1'b0;
            r_swallow <= 1'b0;
            r_fq <= 1'b0;
            r_row_open <= 1'b0;
            r_nonempty <= 1'b0;
            r_cur_line <= LINE_FIRST;
            r_row_line <= LINE_FIRST;
            r_quote_line <= '0;
            r_fcnt <= '0;
            r_expected <= '0;
            r_first_seen <= 1'b0;
            r_bom <= 2'd0;
            r_in_first <= 1'b1;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_inq <= n_inq;
            r_qp <= n_qp;
            r_swallow <= n_swallow;
            r_fq <= n_fq;
            r_row_open <= n_row_open;
            r_nonempty <= n_nonempty;
            r_cur_line <= n_cur_line;
            r_row_line <= n_row_line;
            r_quote_line <= n_quote_line;
            r_fcnt <= n_fcnt;
            r_expected <= n_expected;
            r_first_seen <= n_first_seen;
            r_bom <= n_bom;
            r_in_first <= n_in_first;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ===== hdl/csvp_queue.sv =====
`timescale 1ns / 1ps
module csvp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csvp_pkg::t_bundle i_data,
    output logic              o_full,
    input  logic              i_pop,
    output csvp_pkg::t_bundle o_data,
    output logic              o_empty
);
    import csvp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_bundle          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full = (r_cnt == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/csvp_back.sv =====
`timescale 1ns / 1ps
module csvp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  csvp_pkg::t_bundle               i_data,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [csvp_pkg::M_TDATA_W-1:0]  o_tdata,
    output logic [1:0]                      o_tuser,
    output logic                            o_tlast
);
    import csvp_pkg::*;

    t_bundle              r_cur;
    logic                 r_valid;
    logic [EVT_IDX_W-1:0] r_idx;

    logic                 w_last, w_done;
    t_evt                 w_evt;
    t_err                 w_err;
    logic [TOTAL_W-1:0]   w_total;
    logic [LINE_BITS-1:0] w_line;

    assign w_last = (({1'b0, r_idx} + 1'b1) == r_cur.cnt);
    assign w_done = r_valid && i_tready && w_last;
    assign o_pop = !i_empty && (!r_valid || w_done);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx <= '0;
        end else if (w_done) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_tready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_comb begin
        w_evt = r_cur.evt[r_idx];
        w_err = (w_evt.kind == KIND_ERR) ? r_cur.err : ERR_NONE;
        w_total = (w_evt.kind == KIND_EOR) ? r_cur.total : '0;
        w_line = (w_evt.kind == KIND_ERR && r_cur.err == ERR_COUNT) ? r_cur.row_line
                                                                     : r_cur.line;
    end

    assign o_tvalid = r_valid;
    assign o_tlast = w_last;
    assign o_tuser = w_evt.kind;
    assign o_tdata = {{(M_TDATA_W - OUT_PAYLOAD_W){1'b0}}, r_cur.row_line, w_line,
                      w_err, r_cur.hdr, w_total, r_cur.pos, r_cur.quoted, w_evt.data};

endmodule

// ===== hdl/csv_record_parser_top.sv =====
`timescale 1ns / 1ps
// CSV record parser. Raw text enters on the slave stream one byte per transfer; tuser[0]
// marks end of input, in which case the byte is ignored. Events leave on the master stream:
// tuser carries the event kind (field byte, end of field, end of record, error) and tdata
// carries the data byte and the field, record and line information. tlast marks the final
// event caused by one input transfer. Input bytes that cause no event produce no transfer.
// The configuration port (separator, strict row counts, header flag) is written while the
// stream is idle; writes take effect at the next clock edge.
// Throughput: one input byte per cycle while each byte causes at most one event and the
// receiver is ready. A byte that causes several events (end of record, a flushed byte-order
// mark) holds the output for each of its events in turn; a four-entry queue between the
// parser and the output stage absorbs short bursts before the input is held off. An event
// is written into the queue and then into the output stage register before it is sent.
// After an error event the parser accepts and drops all input until reset. Reset clears the
// parser, the queue and the output stage and restores the default configuration. When the
// receiver stalls, the current event holds, the queue fills, and then tready drops.
module csv_record_parser_top #(
    parameter int MAX_FIELDS = csvp_pkg::DEF_MAX_FIELDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration writes.
    input  logic                            i_cfg_we,
    input  logic [csvp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [csvp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Input stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // [7:0] in_byte
    input  logic                            i_s_axis_tuser,  // [0] end_of_input
    // Event stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] data_byte, [8] field_was_quoted, [18:9] field_position,
    // [29:19] record_field_total, [30] record_is_header, [32:31] error_code,
    // [56:33] line_number, [80:57] record_start_line, upper bits zero
    output logic [csvp_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic [1:0]                      o_m_axis_tuser,  // [1:0] event_kind
    output logic                            o_m_axis_tlast   // last_of_run
);
    import csvp_pkg::*;

    logic    w_accept, w_push, w_full, w_pop, w_empty;
    t_bundle w_front, w_head;

    assign o_s_axis_tready = !w_full;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    // Only bytes that produce events take a queue slot.
    assign w_push = w_accept && (w_front.cnt != '0);

    csvp_front #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_byte      (i_s_axis_tdata),
        .i_eoi       (i_s_axis_tuser),
        .o_bundle    (w_front)
    );

    csvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    csvp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

    // An error always ends the run of events of its input byte.
    a_err_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_ERR) |-> o_m_axis_tlast)
        else $error("error event not marked last");

    // An error code appears exactly on error events.
    a_err_code_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tuser == KIND_ERR) == (o_m_axis_tdata[32:31] != ERR_NONE)))
        else $error("error code does not match event kind");

    // The record field total is only reported with end of record.
    a_total_on_eor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != KIND_EOR) |-> (o_m_axis_tdata[29:19] == '0))
        else $error("field total outside end of record");

    // A queue that is empty cannot be popped.
    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_empty |-> !w_pop)
        else $error("pop from empty event queue");

endmodule
